### src/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the min tracking stack
// Beat structs for both channels, command and status codes, cell control.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int ENTRY_WIDTH = DATA_WIDTH + 2;
    localparam int COUNT_WIDTH = 9;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic                          cmd;
        logic signed [DATA_WIDTH-1:0]  push_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  top_value;
        logic signed [DATA_WIDTH-1:0]  min_value;
        logic [COUNT_WIDTH-1:0]        entry_count;
        logic                          is_empty;
        logic [1:0]                    status;
    } t_out_beat;

    // shift control broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

### src/mts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// Holds one encoded entry; on push it takes its upper neighbor's entry, on
// pop its lower neighbor's entry, otherwise it holds.
// ----------------------------------------------------------------------------
module mts_cell (
    input  logic                                 i_clk,
    input  mts_pkg::t_shift_ctl                  i_ctl,
    input  logic [mts_pkg::ENTRY_WIDTH-1:0]      i_from_up,
    input  logic [mts_pkg::ENTRY_WIDTH-1:0]      i_from_down,
    output logic [mts_pkg::ENTRY_WIDTH-1:0]      o_entry
);
    import mts_pkg::*;

    logic [ENTRY_WIDTH-1:0] r_entry;

    // shift register slot, payload only, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

### src/min_tracking_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_core: LIFO stack with constant-time running minimum
// The result beat of an accepted input beat appears in the next cycle.
// Throughput: one item per cycle unless output stalls; the pop path (minimum
// restore followed by the decode compare of the next entry) sets the cycle time.
// Reset: pointer cleared, minimum set to the most positive value, output
// register emptied. Stack cells are not cleared; only written cells are read.
// ----------------------------------------------------------------------------
module min_tracking_stack_core #(
    parameter int DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  mts_pkg::t_in_beat     i_in,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output mts_pkg::t_out_beat    o_out,
    input  logic                  i_out_stall
);
    import mts_pkg::*;

    localparam int PTR_W = $clog2(DEPTH + 1);
    localparam int DW    = DATA_WIDTH;
    localparam int EW    = ENTRY_WIDTH;

    logic [PTR_W-1:0]       r_sp, n_sp;
    logic signed [DW-1:0]   r_min, n_min;
    logic                   r_out_valid;
    t_out_beat              r_out, n_out;

    logic [EW-1:0]          w_entry [DEPTH];
    logic [EW-1:0]          w_head;
    t_shift_ctl             w_ctl;
    logic                   w_accept;

    logic                   w_empty, w_full;
    logic signed [EW-1:0]   w_v_ext, w_min_ext, w_enc, w_restored;
    logic signed [EW-1:0]   w_e0, w_e1, w_nmin_ext;
    logic signed [DW-1:0]   w_top;
    logic [1:0]             w_status;
    logic [PTR_W+COUNT_WIDTH-1:0] w_sp_wide;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // operand preparation
    assign w_empty    = (r_sp == '0);
    assign w_full     = (r_sp == PTR_W'(DEPTH));
    assign w_v_ext    = {{2{i_in.push_value[DW-1]}}, i_in.push_value};
    assign w_min_ext  = {{2{r_min[DW-1]}}, r_min};
    assign w_enc      = {w_v_ext[EW-2:0], 1'b0} - w_min_ext;
    assign w_restored = {w_min_ext[EW-2:0], 1'b0} - w_e0;
    assign w_e0       = w_entry[0];
    assign w_e1       = w_entry[1];
    assign w_nmin_ext = {{2{n_min[DW-1]}}, n_min};

    // command decode and next state
    always_comb begin
        n_sp     = r_sp;
        n_min    = r_min;
        w_ctl    = '0;
        w_head   = w_v_ext;
        w_status = ST_OK;
        w_top    = (w_e0 < w_min_ext) ? r_min : w_e0[DW-1:0];
        unique case (i_in.cmd)
            CMD_PUSH: begin
                if (w_full) begin
                    w_status = ST_PUSH_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_sp       = r_sp + 1'b1;
                    n_min      = i_in.push_value;
                    w_top      = i_in.push_value;
                    if (!w_empty && (i_in.push_value < r_min)) begin
                        w_head = w_enc;
                    end else if (!w_empty) begin
                        n_min  = r_min;
                    end
                end
            end
            CMD_POP: begin
                if (w_empty) begin
                    w_status = ST_POP_EMPTY;
                end else begin
                    w_ctl.pop = w_accept;
                    n_sp      = r_sp - 1'b1;
                    if (w_e0 < w_min_ext) begin
                        n_min = w_restored[DW-1:0];
                    end
                    w_top = (w_e1 < w_nmin_ext) ? n_min : w_e1[DW-1:0];
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // result beat
    assign w_sp_wide = {{COUNT_WIDTH{1'b0}}, n_sp};

    always_comb begin
        n_out.entry_count = w_sp_wide[COUNT_WIDTH-1:0];
        n_out.status      = w_status;
        if (n_sp == '0) begin
            n_out.top_value = '0;
            n_out.min_value = '0;
            n_out.is_empty  = 1'b1;
        end else begin
            n_out.top_value = w_top;
            n_out.min_value = n_min;
            n_out.is_empty  = 1'b0;
        end
    end

    // control and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_min       <= {1'b0, {(DW-1){1'b1}}};
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_sp        <= n_sp;
                r_min       <= n_min;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // row of stack cells, cell 0 is the top
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic [EW-1:0] w_up, w_down;
            if (k == 0) begin : g_top
                assign w_up = w_head;
            end else begin : g_mid
                assign w_up = w_entry[k-1];
            end
            if (k == DEPTH - 1) begin : g_bot
                assign w_down = w_entry[k];
            end else begin : g_inner
                assign w_down = w_entry[k+1];
            end
            mts_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_from_up   (w_up),
                .i_from_down (w_down),
                .o_entry     (w_entry[k])
            );
        end
    endgenerate

    // checks
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PTR_W'(DEPTH))
        else $error("stack pointer beyond depth");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.cmd == CMD_POP) && w_empty |=>
            (o_out.status == ST_POP_EMPTY) && o_out.is_empty && (r_sp == '0))
        else $error("pop on empty not flagged");

    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in.cmd == CMD_PUSH) && w_full |=>
            (o_out.status == ST_PUSH_FULL) && (r_sp == $past(r_sp))
            && (r_min == $past(r_min)))
        else $error("push on full changed state");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted beat produced no result");

endmodule
